FILE: hw/rtl/circular_deque_macros.svh
// Assertion macros used by the deque controller RTL.
// With SYNTH defined, the macros expand to nothing.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define CD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`else

`define CD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/cd_pkg.sv
`timescale 1ns / 1ps

package cd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 16;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [DATA_WIDTH-1:0] cd_data_t;
    typedef logic [IDX_W-1:0]      cd_idx_t;
    typedef logic [CNT_W-1:0]      cd_cnt_t;

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_QUERY      = 3'd4
    } cd_req_t;

    // Row-wide data movement decided by the controller for one beat.
    typedef struct packed {
        logic    push_front;
        logic    push_back;
        logic    pop_front;
        cd_idx_t back_idx;
    } cd_cmd_t;

    // What one cell does in the coming cycle.
    typedef struct packed {
        logic take_front;
        logic take_back;
        logic load;
    } cd_cell_ctl_t;

    // Deque status seen by the output side.
    typedef struct packed {
        cd_cnt_t count;
        logic    empty;
        logic    full;
        logic    accepted;
    } cd_status_t;

endpackage

FILE: hw/rtl/cd_cell.sv
`timescale 1ns / 1ps

// One storage cell of the deque row: holds one word and moves it along the row.
module cd_cell
    import cd_pkg::*;
(
    input  logic         clk,
    input  cd_cell_ctl_t ctl,
    input  cd_data_t     front_data,
    input  cd_data_t     back_data,
    input  cd_data_t     load_data,
    output cd_data_t     data
);

    cd_data_t data_reg;
    cd_data_t data_next;

    always_comb
    begin
        priority if (ctl.load)
        begin
            data_next = load_data;
        end
        else if (ctl.take_front)
        begin
            data_next = front_data;
        end
        else if (ctl.take_back)
        begin
            data_next = back_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: hw/rtl/cd_ctrl.sv
`timescale 1ns / 1ps
`include "circular_deque_macros.svh"

// Element count, capacity register and per-beat command generation.
module cd_ctrl
    import cd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_fire,
    input  logic [2:0] req_type,
    input  logic       cfg_we,
    input  cd_cnt_t    cfg_wdata,
    output cd_cmd_t    cmd,
    output cd_status_t status
);

    cd_cnt_t cap_reg;
    cd_cnt_t cap_next;
    cd_cnt_t count_reg;
    cd_cnt_t count_next;
    logic    ok_reg;
    logic    ok_next;
    logic    full;
    logic    empty;
    cd_req_t req;

    assign full  = (count_reg >= cap_reg);
    assign empty = (count_reg == '0);
    assign req   = cd_req_t'(req_type);

    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cap_next = CNT_W'(1);
        end
        else if (cfg_wdata > CNT_W'(DEPTH))
        begin
            cap_next = CNT_W'(DEPTH);
        end
        else
        begin
            cap_next = cfg_wdata;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        ok_next        = ok_reg;
        cmd.push_front = 1'b0;
        cmd.push_back  = 1'b0;
        cmd.pop_front  = 1'b0;
        cmd.back_idx   = count_reg[IDX_W-1:0];
        if (cfg_we)
        begin
            count_next = '0;
        end
        else if (req_fire)
        begin
            ok_next = 1'b0;
            unique case (req)
                REQ_PUSH_FRONT:
                begin
                    if (!full)
                    begin
                        cmd.push_front = 1'b1;
                        count_next     = count_reg + CNT_W'(1);
                        ok_next        = 1'b1;
                    end
                end
                REQ_PUSH_BACK:
                begin
                    if (!full)
                    begin
                        cmd.push_back = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                        ok_next       = 1'b1;
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (!empty)
                    begin
                        cmd.pop_front = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                        ok_next       = 1'b1;
                    end
                end
                REQ_POP_BACK:
                begin
                    if (!empty)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        ok_next    = 1'b1;
                    end
                end
                REQ_QUERY:
                begin
                    ok_next = 1'b1;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CNT_W'(DEPTH);
            count_reg <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cap_next;
            end
            count_reg <= count_next;
            ok_reg    <= ok_next;
        end
    end

    assign status.count    = count_reg;
    assign status.empty    = empty;
    assign status.full     = full;
    assign status.accepted = ok_reg;

    `CD_ASSERT_NOW(a_count_in_cap, clk, rst_n, 1'b1, count_reg <= cap_reg)
    `CD_ASSERT_NEXT(a_cfg_clears, clk, rst_n, cfg_we, count_reg == '0)
    `CD_ASSERT_NEXT(a_full_push_holds, clk, rst_n,
        req_fire && !cfg_we && full && (req_type == REQ_PUSH_FRONT || req_type == REQ_PUSH_BACK),
        $stable(count_reg) && !ok_reg)
    `CD_ASSERT_NEXT(a_pop_decrements, clk, rst_n,
        req_fire && !cfg_we && !empty && (req_type == REQ_POP_FRONT || req_type == REQ_POP_BACK),
        count_reg == $past(count_reg) - CNT_W'(1))

endmodule

FILE: hw/rtl/circular_deque.sv
`timescale 1ns / 1ps

// Double-ended queue of up to 16 words of 16 bits, held in a row of cells with the
// front element always in cell 0. A push at the front shifts the whole row one cell
// toward the back, a pop at the front shifts it one cell toward the front, a push at
// the back loads the cell just past the rear element, and a pop at the back only
// lowers the element count. Requests arrive on the slave stream (kind in tuser, data
// word in tdata) and every request produces exactly one result beat on the master
// stream that reports whether it succeeded, the front and rear words with their
// valid flags, and the empty and full flags after the request. A push is refused
// when the count has reached the active capacity and a pop is refused when the
// deque is empty; refused and unknown requests change nothing and report accepted
// low. Writing the capacity register (values below 1 act as 1, above 16 act as 16)
// empties the deque; write it only while no result is outstanding.
// A request is applied to the cell row when it is accepted, and its result
// appears in the output slot on the following cycle. The block takes a new
// request in any cycle in which the output slot is empty or being drained, so with
// tready held high on the master side it sustains one request per clock; the
// single output slot sets that limit.
module circular_deque
    import cd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] push_value
    input  logic [2:0]  s_axis_tuser,  // [2:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] accepted, [16:1] head_value, [17] head_valid, [33:18] tail_value,
    // [34] tail_valid, [35] is_empty, [36] is_full, [39:37] zero
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);

    logic       req_fire;
    logic       out_valid_reg;
    logic       out_valid_next;
    cd_cmd_t    cmd;
    cd_status_t status;
    cd_data_t   cell_data [DEPTH];
    cd_idx_t    tail_idx;
    logic       has;
    cd_data_t   head_value;
    cd_data_t   tail_value;

    // The output slot holds one result; a new request may enter when it drains.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign req_fire      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (req_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    cd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_fire  (req_fire),
        .req_type  (s_axis_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (CNT_W'(cfg_wdata)),
        .cmd       (cmd),
        .status    (status)
    );

    // The cell row. Cell 0 takes the pushed word on a front push; the last cell
    // takes zero on a front pop, which only fills a slot past the live elements.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cd_cell_ctl_t ctl;
        cd_data_t     front_data;
        cd_data_t     back_data;

        assign ctl.take_front = cmd.push_front;
        assign ctl.take_back  = cmd.pop_front;
        assign ctl.load       = cmd.push_back && (cmd.back_idx == IDX_W'(i));

        if (i == 0)
        begin : g_first
            assign front_data = DATA_WIDTH'(s_axis_tdata);
        end
        else
        begin : g_mid
            assign front_data = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign back_data = '0;
        end
        else
        begin : g_inner
            assign back_data = cell_data[i+1];
        end

        cd_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .front_data (front_data),
            .back_data  (back_data),
            .load_data  (DATA_WIDTH'(s_axis_tdata)),
            .data       (cell_data[i])
        );
    end

    // The result reflects the state the last request left; no request can move it
    // again until the slot drains; only a capacity write moves it while the beat waits.
    assign has        = !status.empty;
    assign tail_idx   = IDX_W'(status.count - CNT_W'(1));
    assign head_value = has ? cell_data[0] : '0;
    assign tail_value = has ? cell_data[tail_idx] : '0;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            status.full,
                            status.empty,
                            has,
                            16'(tail_value),
                            has,
                            16'(head_value),
                            status.accepted};

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for circular_deque.
//
// Requests go in on the slave stream one beat at a time. Each beat the block
// accepts is run through a behavioral deque model kept here, and the status that
// the model reports afterwards is queued. Every result beat from the master stream
// is then checked, field by field, against the oldest queued status.
//
// The capacity register is only written once every queued status has been
// matched. Each write also empties the model.
module tb_top;
    import cd_pkg::*;

    // Clock period is 10 ns. Reset is asynchronous and active low. It is held from
    // the start of the run and never asserted again.
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 4;
    // Cycles allowed to pass after the last result before a register write or
    // before the verdict. The block answers in the cycle after a request is accepted.
    localparam int SETTLE_CYCLES  = 4;
    // Cycles with no beat on either stream before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 150;
    localparam int PHASE_COUNT    = 8;

    // Status reported for one request, in the order of the result fields.
    typedef struct {
        logic     accepted;
        cd_data_t head_value;
        logic     head_valid;
        cd_data_t tail_value;
        logic     tail_valid;
        logic     is_empty;
        logic     is_full;
    } deque_status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [39:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;

    // Model state. The front of the deque is entry 0 of deque_words.
    cd_data_t      deque_words[$];
    int unsigned   deque_cap = DEPTH;

    // Statuses the block still owes, oldest first.
    deque_status_t pending_status[$];
    deque_status_t oldest_status;

    int   error_count = 0;
    int   quiet_cycles = 0;
    // When these flags are low, the matching side runs flat out.
    logic sender_idles = 1'b1;
    logic receiver_stalls = 1'b1;

    circular_deque DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // A written capacity below 1 acts as 1, and one above DEPTH acts as DEPTH.
    function automatic int unsigned effective_capacity(logic [4:0] value);
        if (value == 0)
            return 1;
        if (value > DEPTH)
            return DEPTH;
        return value;
    endfunction

    // Applies one request to the model and returns the status after it. Refused
    // and unknown requests leave the deque as it was.
    function automatic deque_status_t apply_request(logic [2:0] kind, cd_data_t word);
        deque_status_t status;
        logic          full;
        logic          empty;
        full = deque_words.size() >= deque_cap;
        empty = deque_words.size() == 0;
        status.accepted = 1'b0;
        case (kind)
            REQ_PUSH_FRONT:
                if (!full)
                begin
                    deque_words.push_front(word);
                    status.accepted = 1'b1;
                end
            REQ_PUSH_BACK:
                if (!full)
                begin
                    deque_words.push_back(word);
                    status.accepted = 1'b1;
                end
            REQ_POP_FRONT:
                if (!empty)
                begin
                    void'(deque_words.pop_front());
                    status.accepted = 1'b1;
                end
            REQ_POP_BACK:
                if (!empty)
                begin
                    void'(deque_words.pop_back());
                    status.accepted = 1'b1;
                end
            REQ_QUERY:
                status.accepted = 1'b1;
            default:
                status.accepted = 1'b0;
        endcase
        // An empty deque reports zero words with both valid flags low.
        status.head_valid = deque_words.size() != 0;
        status.tail_valid = status.head_valid;
        status.head_value = status.head_valid ? deque_words[0] : '0;
        status.tail_value = status.tail_valid ? deque_words[deque_words.size() - 1] : '0;
        status.is_empty = !status.head_valid;
        status.is_full = deque_words.size() >= deque_cap;
        return status;
    endfunction

    function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    // Sends one request beat. Call it at a falling edge. It returns at the falling
    // edge after the beat is taken, with tvalid still high. The caller must then
    // either send again or lower tvalid at once. That way tvalid is never lowered
    // and raised again within one step.
    task automatic send_request(logic [2:0] kind, cd_data_t word);
        int gap;
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_status.push_back(apply_request(kind, word));
        @(negedge clk);
    endtask

    // Stops the request stream and waits until every owed result has been
    // checked. Then it lets the block settle before returning.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // A capacity write empties the deque, so the model is cleared with it.
    task automatic write_capacity(logic [4:0] value);
        wait_for_results();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        deque_cap = effective_capacity(value);
        deque_words.delete();
    endtask

    // Random request kind. push_pct steers the mix toward filling or draining.
    // A few unknown kinds and queries are mixed in.
    function automatic logic [2:0] pick_kind(int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return 3'($urandom_range(5, 7));
        if (roll < 8)
            return REQ_QUERY;
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        return $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
    endfunction

    // Random data word, with extra weight on all zeros and all ones.
    function automatic cd_data_t pick_word();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return cd_data_t'($urandom_range(0, 65535));
    endfunction

    // Right after reset: queries and pops on an empty deque, and the unknown kinds.
    // The data words sent with these are meant to be ignored.
    task automatic test_empty_deque();
        send_request(REQ_QUERY, 16'h0000);
        send_request(REQ_POP_FRONT, 16'hFFFF);
        send_request(REQ_POP_BACK, 16'hFFFF);
        send_request(3'd5, 16'hFFFF);
        send_request(3'd6, 16'h0000);
        send_request(3'd7, 16'hFFFF);
    endtask

    // A written capacity of zero acts as one slot. The second push of either kind
    // is refused, and so is a pop once the deque is empty again.
    task automatic test_single_slot();
        write_capacity(5'd0);
        send_request(REQ_PUSH_FRONT, 16'hFFFF);
        send_request(REQ_PUSH_BACK, 16'h1234);
        send_request(REQ_PUSH_FRONT, 16'h0001);
        send_request(REQ_QUERY, 16'h0000);
        send_request(REQ_POP_BACK, 16'h0000);
        send_request(REQ_POP_FRONT, 16'h0000);
    endtask

    // With two slots, a push at each end fills the deque. A third push is refused.
    task automatic test_two_slots();
        write_capacity(5'd2);
        send_request(REQ_PUSH_BACK, 16'h0000);
        send_request(REQ_PUSH_FRONT, 16'hAAAA);
        send_request(REQ_PUSH_BACK, 16'h5555);
        send_request(REQ_POP_FRONT, 16'h0000);
        send_request(REQ_POP_BACK, 16'h0000);
    endtask

    // A written capacity above DEPTH acts as DEPTH. An unknown kind sent while the
    // deque holds data must leave it unchanged.
    task automatic test_oversized_capacity();
        write_capacity(5'd31);
        send_request(REQ_PUSH_FRONT, 16'h5555);
        send_request(REQ_PUSH_BACK, 16'h8001);
        send_request(3'd7, 16'hFFFF);
        send_request(REQ_POP_FRONT, 16'h0000);
        send_request(REQ_POP_BACK, 16'h0000);
    endtask

    // Random traffic in phases, each phase at its own capacity. Within a phase the
    // mix swings between filling and draining. Each stretch is long enough to reach
    // full or empty, so refusals occur at every capacity. The last phase runs with no
    // idling on either side.
    task automatic test_random_traffic();
        logic [4:0] capacity;
        int         stretch;
        int         push_pct;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       capacity = 5'd16;
                1:       capacity = 5'd1;
                2:       capacity = 5'd0;
                3:       capacity = 5'd31;
                4:       capacity = 5'd3;
                7:       capacity = 5'd16;
                default: capacity = 5'($urandom_range(0, 31));
            endcase
            write_capacity(capacity);
            if (phase == PHASE_COUNT - 1)
            begin
                sender_idles    = 1'b0;
                receiver_stalls = 1'b0;
            end
            else
            begin
                sender_idles    = $urandom_range(0, 3) != 0;
                receiver_stalls = $urandom_range(0, 3) != 0;
            end
            stretch = 2 * deque_cap + 4;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                push_pct = ((n / stretch) % 2 == 0) ? 80 : 20;
                send_request(pick_kind(push_pct), pick_word());
            end
        end
    endtask

    // The receiver stalls in bursts of random length. tready only changes at
    // falling edges.
    always
    begin
        @(negedge clk);
        if (receiver_stalls && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        m_axis_tready <= 1'b1;
    end

    // Result checker. Outputs are sampled at the rising edge, where a beat is
    // transferred. Each beat is matched against the oldest owed status.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_status.size() == 0)
            begin
                $error("result beat 0x%0h arrived with no request outstanding", m_axis_tdata);
                error_count++;
            end
            else
            begin
                oldest_status = pending_status.pop_front();
                compare_field("accepted", oldest_status.accepted, m_axis_tdata[0]);
                compare_field("head_value", oldest_status.head_value, m_axis_tdata[16:1]);
                compare_field("head_valid", oldest_status.head_valid, m_axis_tdata[17]);
                compare_field("tail_value", oldest_status.tail_value, m_axis_tdata[33:18]);
                compare_field("tail_valid", oldest_status.tail_valid, m_axis_tdata[34]);
                compare_field("is_empty", oldest_status.is_empty, m_axis_tdata[35]);
                compare_field("is_full", oldest_status.is_full, m_axis_tdata[36]);
            end
        end
    end

    // Watchdog. The count restarts whenever a beat moves on either stream, or while
    // reset is held.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_deque();
        test_single_slot();
        test_two_slots();
        test_oversized_capacity();
        test_random_traffic();

        wait_for_results();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: circular_deque.f
+incdir+hw/rtl
hw/rtl/cd_pkg.sv
hw/rtl/cd_cell.sv
hw/rtl/cd_ctrl.sv
hw/rtl/circular_deque.sv
tb/sv/tb_top.sv
